@@ hdl/abld_pkg.sv @@
package abld_pkg;

	localparam int MAX_ANCHORS = 4;
	localparam int MAX_POINTS = 8;
	localparam int MAP_SIZE = 1024;

	localparam int COL_W = 10;
	localparam int IDX_W = 3;
	localparam int SCORE_W = 16;
	localparam int DELTA_W = 16;
	localparam int SIZE_W = 16;
	localparam int STRIDE_W = 9;
	localparam int TABLE_W = 64;
	localparam int CNT_W = 3;
	localparam int COORD_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TDATA_IN_W = 112;
	localparam int TDATA_OUT_W = 128;

	localparam int CX_W = 24;
	localparam int PX_W = 38;
	localparam int R_W = 30;
	localparam int K_W = 6;
	localparam int TERM_W = 31;
	localparam int SUM_W = 32;
	localparam int PW_W = 42;

	localparam logic [R_W-1:0] LN2_Q30 = 30'd744261118;
	localparam logic [20:0] INV_LN2_Q20 = 21'd1512775;

	localparam int TAYLOR_TERMS = 15;
	localparam int EXP_LAT = 3 + 3 * TAYLOR_TERMS + 2;
	localparam int DLY_N = EXP_LAT - 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESH,
		REG_STRIDE,
		REG_OFFSET,
		REG_WIDTHS,
		REG_HEIGHTS,
		REG_COUNT,
		REG_DENSE
	} cfg_reg_t;

	typedef struct packed {
		logic               mode;
		logic [COL_W-1:0]   col;
		logic [COL_W-1:0]   row;
		logic [IDX_W-1:0]   anchor;
		logic [IDX_W-1:0]   point;
		logic [SCORE_W-1:0] score;
	} tag_t;

	typedef struct packed {
		tag_t                   tag;
		logic signed [PX_W-1:0] px;
		logic signed [PX_W-1:0] py;
	} dly_t;

	typedef struct packed {
		logic [R_W-1:0]        r;
		logic signed [K_W-1:0] k;
		logic [SIZE_W-1:0]     size;
	} exp_side_t;

	typedef struct packed {
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
		logic [SCORE_W-1:0] score;
		logic [IDX_W-1:0]   point;
		logic [IDX_W-1:0]   anchor;
		logic [COL_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               kind;
	} res_t;

endpackage

@@ hdl/anchor_box_landmark_decode_unit.sv @@
// Channel   Direction  Payload
// cfg       in         cfg_index selects the register, cfg_data carries its value
// s_axis    in         tuser: mode; tdata: cell fields, score and four deltas
// m_axis    out        tuser: kind; tdata: echoed fields and four coordinates
//
// One item is accepted per cycle while s_axis_tready is high.
// The pipeline depth is set by the exp series, three stages for each of its 15 terms.
// Reset clears all valid bits and loads the register defaults.
// A skid register behind the output register absorbs a stall; s_axis_tready
// falls only while the skid register holds a result.
module anchor_box_landmark_decode_unit import abld_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cell_col, cell_row, anchor_index, point_index, score, delta_a..delta_d, zero pad
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
	// mode
	input  logic [0:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_col, out_row, out_anchor, out_point, out_score, left_x, top_y,
	// right_x, bottom_y, zero pad
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,
	// kind
	output logic [0:0]             m_axis_tuser
);

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [44:0] v);
		if (v > 45'sd524287) begin
			return 20'h7FFFF;
		end else if (v < -45'sd524288) begin
			return 20'h80000;
		end
		return COORD_W'(v);
	endfunction

	logic [SCORE_W-1:0]  thr_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [SIZE_W-1:0]   offset_q;
	logic [TABLE_W-1:0]  widths_q;
	logic [TABLE_W-1:0]  heights_q;
	logic [CNT_W-1:0]    count_q;
	logic                dense_q;

	logic en;

	tag_t                      tag_in;
	logic [CNT_W-1:0]          cnt_eff;
	logic [IDX_W-1:0]          hi_off;
	logic                      a_lo;
	logic                      keep_in;

	logic                      valid_s1;
	tag_t                      tag_s1;
	logic [1:0]                entry_s1;
	logic                      dense_s1;
	logic signed [DELTA_W-1:0] da_s1, db_s1, dc_s1, dd_s1;

	logic                      valid_s2;
	tag_t                      tag_s2;
	logic [SIZE_W-1:0]         w_s2, h_s2;
	logic [CX_W-1:0]           cx_s2, cy_s2;
	logic signed [DELTA_W-1:0] da_s2, db_s2, dc_s2, dd_s2;
	logic [CX_W-1:0]           half;

	logic                      valid_s3;
	tag_t                      tag_s3;
	logic [CX_W-1:0]           cx_s3, cy_s3;
	logic signed [32:0]        dw_s3, dh_s3;

	logic                      valid_s4;
	tag_t                      tag_s4;
	logic signed [PX_W-1:0]    px_s4, py_s4;

	logic                      dvalid_s [DLY_N];
	dly_t                      dly_s    [DLY_N];

	logic [PW_W-1:0]           pw, ph;

	dly_t                      last;
	logic signed [44:0]        px2, py2, pwx, phx;
	res_t                      res;
	logic                      arrive;

	res_t                      out_q;
	logic                      out_valid_q;
	res_t                      skid_q;
	logic                      skid_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd32768;
			stride_q <= 9'd8;
			offset_q <= 16'd120;
			widths_q <= 64'd33554688;
			heights_q <= 64'd33554688;
			count_q <= 3'd2;
			dense_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESH: thr_q <= cfg_data[SCORE_W-1:0];
				REG_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[SIZE_W-1:0];
				REG_WIDTHS: widths_q <= cfg_data;
				REG_HEIGHTS: heights_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_DENSE: dense_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en = !skid_valid_q;
	assign s_axis_tready = en;

	assign tag_in.mode = s_axis_tuser[0];
	assign tag_in.col = s_axis_tdata[9:0];
	assign tag_in.row = s_axis_tdata[19:10];
	assign tag_in.anchor = s_axis_tdata[22:20];
	assign tag_in.point = s_axis_tdata[25:23];
	assign tag_in.score = s_axis_tdata[41:26];

	always_comb begin
		if (count_q == CNT_W'(0)) begin
			cnt_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_ANCHORS)) begin
			cnt_eff = CNT_W'(MAX_ANCHORS);
		end else begin
			cnt_eff = count_q;
		end
	end

	assign a_lo = tag_in.anchor < cnt_eff;
	assign hi_off = tag_in.anchor - cnt_eff;
	assign keep_in = (tag_in.score >= thr_q)
		&& (13'(tag_in.col) < 13'(MAP_SIZE))
		&& (13'(tag_in.row) < 13'(MAP_SIZE))
		&& (a_lo || (dense_q && hi_off < cnt_eff))
		&& (!tag_in.mode || 4'(tag_in.point) < 4'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid && keep_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_in;
			entry_s1 <= a_lo ? tag_in.anchor[1:0] : hi_off[1:0];
			dense_s1 <= !a_lo;
			da_s1 <= s_axis_tdata[57:42];
			db_s1 <= s_axis_tdata[73:58];
			dc_s1 <= s_axis_tdata[89:74];
			dd_s1 <= s_axis_tdata[105:90];
		end
	end

	assign half = dense_s1 ? CX_W'(stride_q[STRIDE_W-1:1]) : CX_W'(0);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			w_s2 <= widths_q[16 * entry_s1 +: SIZE_W];
			h_s2 <= heights_q[16 * entry_s1 +: SIZE_W];
			cx_s2 <= ((CX_W'(tag_s1.col) * CX_W'(stride_q)) << 4) + CX_W'(offset_q) + (half << 4);
			cy_s2 <= ((CX_W'(tag_s1.row) * CX_W'(stride_q)) << 4) + CX_W'(offset_q) + (half << 4);
			da_s2 <= da_s1;
			db_s2 <= db_s1;
			dc_s2 <= dc_s1;
			dd_s2 <= dd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= tag_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			dw_s3 <= 33'(da_s2 * $signed({1'b0, w_s2}));
			dh_s3 <= 33'(db_s2 * $signed({1'b0, h_s2}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4 <= tag_s3;
			px_s4 <= $signed({2'b0, cx_s3, 12'b0}) + PX_W'(dw_s3);
			py_s4 <= $signed({2'b0, cy_s3, 12'b0}) + PX_W'(dh_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DLY_N; j++) begin
				dvalid_s[j] <= 1'b0;
			end
		end else if (en) begin
			dvalid_s[0] <= valid_s4;
			for (int j = 1; j < DLY_N; j++) begin
				dvalid_s[j] <= dvalid_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= '{tag: tag_s4, px: px_s4, py: py_s4};
			for (int j = 1; j < DLY_N; j++) begin
				dly_s[j] <= dly_s[j-1];
			end
		end
	end

	abld_exp u_exp_w (
		.clk    (clk),
		.en     (en),
		.delta  (dc_s2),
		.size   (w_s2),
		.scaled (pw)
	);

	abld_exp u_exp_h (
		.clk    (clk),
		.en     (en),
		.delta  (dd_s2),
		.size   (h_s2),
		.scaled (ph)
	);

	assign last = dly_s[DLY_N-1];
	assign px2 = 45'(last.px) <<< 1;
	assign py2 = 45'(last.py) <<< 1;
	assign pwx = $signed({3'b0, pw});
	assign phx = $signed({3'b0, ph});

	always_comb begin
		res.kind = last.tag.mode;
		res.col = last.tag.col;
		res.row = last.tag.row;
		res.anchor = last.tag.anchor;
		res.score = last.tag.score;
		if (last.tag.mode) begin
			res.point = last.tag.point;
			res.left = sat_coord((45'(last.px) + 45'sd2048) >>> 12);
			res.top = sat_coord((45'(last.py) + 45'sd2048) >>> 12);
			res.right = '0;
			res.bottom = '0;
		end else begin
			res.point = '0;
			res.left = sat_coord((px2 - pwx + 45'sd69632) >>> 13);
			res.top = sat_coord((py2 - phx + 45'sd69632) >>> 13);
			res.right = sat_coord((px2 + pwx - 45'sd61440) >>> 13);
			res.bottom = sat_coord((py2 + phx - 45'sd61440) >>> 13);
		end
	end

	assign arrive = en && dvalid_s[DLY_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (arrive) begin
			if (!out_valid_q || m_axis_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_q <= skid_q;
			end
		end else if (arrive) begin
			if (!out_valid_q || m_axis_tready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.kind;
	assign m_axis_tdata = {6'b0, out_q.bottom, out_q.right, out_q.top, out_q.left,
		out_q.score, out_q.point, out_q.anchor, out_q.row, out_q.col};

endmodule

@@ hdl/abld_exp.sv @@
module abld_exp import abld_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [DELTA_W-1:0] delta,
	input  logic [SIZE_W-1:0]         size,
	output logic [PW_W-1:0]           scaled
);

	logic signed [37:0]        prod_s1;
	logic signed [DELTA_W-1:0] d_s1;
	logic [SIZE_W-1:0]         size_s1;

	logic signed [K_W-1:0]     k0;
	logic signed [37:0]        x_e;
	logic signed [37:0]        kl;
	logic signed [37:0]        r0_s2;
	logic signed [K_W-1:0]     k0_s2;
	logic [SIZE_W-1:0]         size_s2;

	logic [60:0]       tprod_s [1:TAYLOR_TERMS];
	logic [TERM_W-1:0] tp_s    [1:TAYLOR_TERMS];
	logic [63:0]       tpm_s   [1:TAYLOR_TERMS];
	exp_side_t         sa_s    [1:TAYLOR_TERMS];
	exp_side_t         sb_s    [1:TAYLOR_TERMS];
	exp_side_t         sc_s    [0:TAYLOR_TERMS];
	logic [SUM_W-1:0]  suma_s  [1:TAYLOR_TERMS];
	logic [SUM_W-1:0]  sumb_s  [1:TAYLOR_TERMS];
	logic [SUM_W-1:0]  sum_s   [0:TAYLOR_TERMS];
	logic [TERM_W-1:0] term_s  [0:TAYLOR_TERMS];

	logic [47:0]           prodf_s;
	logic signed [K_W-1:0] kf_s;
	logic [5:0]            sh;
	logic [48:0]           rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 38'(delta * $signed({1'b0, INV_LN2_Q20}));
			d_s1 <= delta;
			size_s1 <= size;
		end
	end

	assign k0 = prod_s1[37:32];
	assign x_e = {{4{d_s1[DELTA_W-1]}}, d_s1, 18'b0};
	assign kl = 38'(k0 * $signed({1'b0, LN2_Q30}));

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s2 <= x_e - kl;
			k0_s2 <= k0;
			size_s2 <= size_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r0_s2 < 38'sd0) begin
				sc_s[0].r <= R_W'(r0_s2 + $signed({8'b0, LN2_Q30}));
				sc_s[0].k <= k0_s2 - K_W'(1);
			end else if (r0_s2 >= $signed({8'b0, LN2_Q30})) begin
				sc_s[0].r <= R_W'(r0_s2 - $signed({8'b0, LN2_Q30}));
				sc_s[0].k <= k0_s2 + K_W'(1);
			end else begin
				sc_s[0].r <= R_W'(r0_s2);
				sc_s[0].k <= k0_s2;
			end
			sc_s[0].size <= size_s2;
			term_s[0] <= TERM_W'(1) << R_W;
			sum_s[0] <= SUM_W'(1) << R_W;
		end
	end

	for (genvar gi = 1; gi <= TAYLOR_TERMS; gi++) begin : g_term
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / gi);
		logic [31:0] q0;
		logic [32:0] rem;
		logic [31:0] q;

		always_ff @(posedge clk) begin
			if (en) begin
				tprod_s[gi] <= 61'(term_s[gi-1]) * 61'(sc_s[gi-1].r);
				sa_s[gi] <= sc_s[gi-1];
				suma_s[gi] <= sum_s[gi-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tp_s[gi] <= tprod_s[gi][60:30];
				tpm_s[gi] <= 64'(tprod_s[gi][60:30]) * 64'(RECIP);
				sb_s[gi] <= sa_s[gi];
				sumb_s[gi] <= suma_s[gi];
			end
		end

		assign q0 = tpm_s[gi][63:32];
		assign rem = 33'(tp_s[gi]) - 33'(q0 * 32'(gi));
		assign q = (rem >= 33'(gi)) ? q0 + 32'd1 : q0;

		always_ff @(posedge clk) begin
			if (en) begin
				term_s[gi] <= TERM_W'(q);
				sum_s[gi] <= sumb_s[gi] + SUM_W'(q);
				sc_s[gi] <= sb_s[gi];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prodf_s <= 48'(sc_s[TAYLOR_TERMS].size) * 48'(sum_s[TAYLOR_TERMS]);
			kf_s <= sc_s[TAYLOR_TERMS].k;
		end
	end

	assign sh = 6'd18 - kf_s;
	assign rnd = 49'(prodf_s) + (49'd1 << (sh - 6'd1));

	always_ff @(posedge clk) begin
		if (en) begin
			scaled <= PW_W'(rnd >> sh);
		end
	end

endmodule
